// ===== rtl/cucrc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the upload receiver.
package cucrc_pkg;

  localparam int CHUNK_BYTES = 256;
  localparam int FILL_W = 13;
  localparam int SILENCE_W = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [FILL_W-1:0] CHUNK_FULL = FILL_W'(CHUNK_BYTES);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_READY   = 3'd0,
    EV_ACK     = 3'd1,
    EV_OK      = 3'd2,
    EV_BAD     = 3'd3,
    EV_TIMEOUT = 3'd4
  } ev_t;

  typedef enum logic {
    REG_TIMEOUT = 1'b0
  } reg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [31:0] total_size;
    logic [31:0] expected_crc;
  } item_t;

  typedef struct packed {
    ev_t         event_res;
    logic [31:0] final_crc;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cucrc_core.sv =====
// Upload state and result generation, one item per cycle while fire is high.
module cucrc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  cucrc_pkg::item_t     item,
  input  logic [15:0]          timeout_ticks,
  output cucrc_pkg::push_t     push
);

  logic        receiving, receiving_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] bytes_done, bytes_done_next;
  logic [cucrc_pkg::FILL_W-1:0] chunk_fill, chunk_fill_next;
  logic [cucrc_pkg::SILENCE_W-1:0] silence_count, silence_count_next;
  logic [31:0] size_goal, size_goal_next;
  logic [31:0] crc_goal, crc_goal_next;
  logic [cucrc_pkg::SILENCE_W:0] silence_inc;
  logic [31:0] crc_upd, fin;

  always_comb begin
    receiving_next     = receiving;
    running_crc_next   = running_crc;
    bytes_done_next    = bytes_done;
    chunk_fill_next    = chunk_fill;
    silence_count_next = silence_count;
    size_goal_next     = size_goal;
    crc_goal_next      = crc_goal;
    push               = '0;
    crc_upd            = cucrc_pkg::crc_byte(running_crc, item.data_byte);
    fin                = crc_upd ^ cucrc_pkg::CRC_ONES;
    silence_inc        = {1'b0, silence_count} + 17'd1;
    if (fire) begin
      case (cucrc_pkg::op_t'(item.op))
        cucrc_pkg::OP_START: begin
          size_goal_next     = item.total_size;
          crc_goal_next      = item.expected_crc;
          receiving_next     = 1'b1;
          running_crc_next   = cucrc_pkg::CRC_ONES;
          bytes_done_next    = '0;
          chunk_fill_next    = '0;
          silence_count_next = '0;
          push.r0 = '{cucrc_pkg::EV_READY, 32'd0, item.total_size != 32'd0};
          if (item.total_size == 32'd0) begin
            push.num       = 2'd2;
            push.r1        = '{(item.expected_crc == 32'd0) ? cucrc_pkg::EV_OK
                                                            : cucrc_pkg::EV_BAD,
                               32'd0, 1'b1};
            receiving_next = 1'b0;
          end else begin
            push.num = 2'd1;
          end
        end
        cucrc_pkg::OP_BYTE: begin
          if (receiving) begin
            running_crc_next   = crc_upd;
            bytes_done_next    = bytes_done + 32'd1;
            chunk_fill_next    = chunk_fill + 1'b1;
            silence_count_next = '0;
            if (bytes_done_next == size_goal) begin
              push.num        = 2'd2;
              push.r0         = '{cucrc_pkg::EV_ACK, 32'd0, 1'b0};
              push.r1         = '{(fin == crc_goal) ? cucrc_pkg::EV_OK : cucrc_pkg::EV_BAD,
                                  fin, 1'b1};
              receiving_next  = 1'b0;
              chunk_fill_next = '0;
            end else if (chunk_fill_next == cucrc_pkg::CHUNK_FULL) begin
              push.num        = 2'd1;
              push.r0         = '{cucrc_pkg::EV_ACK, 32'd0, 1'b1};
              chunk_fill_next = '0;
            end
          end
        end
        cucrc_pkg::OP_TICK: begin
          if (receiving) begin
            if (silence_inc > {1'b0, timeout_ticks}) begin
              receiving_next     = 1'b0;
              chunk_fill_next    = '0;
              silence_count_next = '0;
              push.num           = 2'd1;
              push.r0            = '{cucrc_pkg::EV_TIMEOUT, 32'd0, 1'b1};
            end else begin
              silence_count_next = silence_inc[cucrc_pkg::SILENCE_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      running_crc   <= cucrc_pkg::CRC_ONES;
      bytes_done    <= '0;
      chunk_fill    <= '0;
      silence_count <= '0;
      size_goal     <= '0;
      crc_goal      <= '0;
    end else begin
      receiving     <= receiving_next;
      running_crc   <= running_crc_next;
      bytes_done    <= bytes_done_next;
      chunk_fill    <= chunk_fill_next;
      silence_count <= silence_count_next;
      size_goal     <= size_goal_next;
      crc_goal      <= crc_goal_next;
    end
  end

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 |-> push.r1.last && !push.r0.last)
    else $error("two results must end on the second");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 |=> !receiving)
    else $error("upload still open after final result");

endmodule

// ===== rtl/cucrc_out_fifo.sv =====
// Result queue taking up to two results per cycle and giving one unless stalled.
module cucrc_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  cucrc_pkg::push_t     push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cucrc_pkg::result_t   out_res
);

  cucrc_pkg::result_t entries [cucrc_pkg::FIFO_DEPTH];
  logic [cucrc_pkg::PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [cucrc_pkg::CNT_W-1:0] count;
  logic pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != '0;
  assign out_res   = entries[rd_ptr];
  assign room      = count <= cucrc_pkg::CNT_W'(cucrc_pkg::FIFO_DEPTH - 2);
  assign wr_ptr1   = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      entries[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cucrc_pkg::PTR_W'(push.num);
      rd_ptr <= rd_ptr + cucrc_pkg::PTR_W'(pop);
      count  <= count + cucrc_pkg::CNT_W'(push.num) - cucrc_pkg::CNT_W'(pop);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= cucrc_pkg::CNT_W'(cucrc_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd0 |-> room)
    else $error("push without room for two results");

endmodule

// ===== rtl/chunked_upload_crc32_receiver_unit.sv =====
// Top level of the chunked upload receiver with CRC-32 check.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    op, data_byte, total_size, expected_crc
//  result    out        result_valid / result_stall event_res, final_crc, last
//  config    in         psel / penable / pready    paddr, pwdata, prdata
//
//  One item per cycle while the queue has room; items are registered in the input
//  register, which feeds the CRC update and counters; results queue in a
//  four-entry buffer, and the input holds while fewer than two slots are free.
//  An item giving two results limits the rate to the one result per cycle
//  drained. Reset is synchronous; it idles the upload and sets timeout_ticks to 2000.
module chunked_upload_crc32_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  data_byte,
  input  logic [31:0] total_size,
  input  logic [31:0] expected_crc,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  event_res,
  output logic [31:0] final_crc,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               held_valid;
  cucrc_pkg::item_t   held;
  logic               room, fire;
  logic [15:0]        timeout_ticks;
  cucrc_pkg::push_t   push;
  cucrc_pkg::result_t res;

  assign pready     = 1'b1;
  assign fire       = held_valid && room;
  assign item_stall = held_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= '{op, data_byte, total_size, expected_crc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= cucrc_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 cucrc_pkg::reg_t'(paddr[2]) == cucrc_pkg::REG_TIMEOUT) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  assign prdata = (cucrc_pkg::reg_t'(paddr[2]) == cucrc_pkg::REG_TIMEOUT) ?
                  {16'd0, timeout_ticks} : 32'd0;

  cucrc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (held),
    .timeout_ticks (timeout_ticks),
    .push          (push)
  );

  cucrc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_res   (res)
  );

  assign event_res = res.event_res;
  assign final_crc = res.final_crc;
  assign last      = res.last;

endmodule
